### hw/rtl/stepper_move_pulse_generator_assert.svh
// Assertion macros for the stepper move pulse generator.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef STEPPER_MOVE_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_MOVE_PULSE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked at every rising edge, switched off while reset is asserted.
`define SMPG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("smpg assertion failed");
// Checked at every rising edge, reset included.
`define SMPG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("smpg assertion failed");
`else
`define SMPG_ASSERT(label, clk, rst_n, prop)
`define SMPG_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### hw/rtl/smpg_pkg.sv
// ----------------------------------------------------------------------------
// smpg_pkg
// Types, constants and helpers for the stepper move pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package smpg_pkg;

    // Time base and accepted rate window
    localparam int unsigned TICK_RATE_HZ = 1000000;
    localparam int unsigned RATE_MIN_HZ  = 20;
    localparam int unsigned RATE_MAX_HZ  = 100000;

    // Field widths
    localparam int unsigned POS_W    = 32;
    localparam int unsigned RATE_W   = 20;
    localparam int unsigned PERIOD_W = 16;

    // Divider: quotient of TICK_RATE_HZ / rate, one bit per cycle
    localparam int unsigned DIV_W = $clog2(TICK_RATE_HZ + 1);
    localparam int unsigned BIT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;
    localparam logic [DIV_W-1:0] TICK_VEC = DIV_W'(TICK_RATE_HZ);

    // Period reset value
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(999);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_REL  = 2'd1,
        OP_ABS  = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } t_state;

    // Step output level for a given pulse state
    function automatic logic step_level(
        input logic                moving,
        input logic [PERIOD_W-1:0] phase,
        input logic [PERIOD_W-1:0] period,
        input logic                pol
    );
        logic [PERIOD_W:0] half;
        half = ({1'b0, period} + {{PERIOD_W{1'b0}}, 1'b1}) >> 1;
        if (moving && ({1'b0, phase} < half)) begin
            return ~pol;
        end
        return pol;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/stepper_move_pulse_generator.sv
// ----------------------------------------------------------------------------
// stepper_move_pulse_generator
// Step/direction pulse generator with a signed 32-bit position counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (valid/ready) carry an opcode: a time base tick, a
//   relative move or an absolute move. Every request returns exactly one
//   result request (valid/ready) with step level, direction, busy flag,
//   position and a reject flag. The user writes the pulse polarity register
//   with i_cfg_we / i_cfg_data only while idle; the block does not enforce it.
// Flow and throughput:
//   Ticks, rejected moves, no-op codes and absolute moves onto the current
//   position have their result registered at accept, seen in the next cycle,
//   so ticks stream at one per cycle while the receiver takes each result.
//   A move that starts motion runs the period division on a shared
//   restoring divider, one quotient bit per cycle, then a load step
//   registers the result. Input ready is low meanwhile.
// Reset:
//   Synchronous, active low. Position, target, pulse count and phase clear,
//   direction goes counter-clockwise, period is 999 ticks, polarity 0.
// Stall:
//   The result sits in an output register; a new request is taken in the
//   same cycle the pending result is taken, and is held off while the
//   receiver stalls.
`default_nettype none

`include "stepper_move_pulse_generator_assert.svh"

module stepper_move_pulse_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_data,
    // input requests
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_opcode,
    input  logic signed [smpg_pkg::POS_W-1:0]   i_move_amount,
    input  logic [smpg_pkg::RATE_W-1:0]         i_pulse_rate_hz,
    input  logic                                i_move_direction,
    // result requests
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_step_level,
    output logic                                o_direction_out,
    output logic                                o_busy_res,
    output logic signed [smpg_pkg::POS_W-1:0]   o_position,
    output logic                                o_command_rejected
);
    import smpg_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                    r_state, n_state;
    logic                      r_pol;

    logic signed [POS_W-1:0]   r_position, n_position;
    logic signed [POS_W-1:0]   r_target, n_target;
    logic [POS_W-1:0]          r_pulses, n_pulses;
    logic                      r_dir, n_dir;
    logic                      r_moving, n_moving;
    logic [PERIOD_W-1:0]       r_period, n_period;
    logic [PERIOD_W-1:0]       r_phase, n_phase;

    // Move waiting for its period
    logic signed [POS_W-1:0]   r_mv_target, n_mv_target;
    logic [POS_W-1:0]          r_mv_count, n_mv_count;
    logic                      r_mv_dir, n_mv_dir;

    // Shared divider
    logic [RATE_W-1:0]         r_divisor, n_divisor;
    logic [RATE_W-1:0]         r_rem, n_rem;
    logic [DIV_W-1:0]          r_quo, n_quo;
    logic [BIT_W-1:0]          r_bit, n_bit;

    // Output register
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_level, n_out_level;
    logic                      r_out_dir, n_out_dir;
    logic                      r_out_busy, n_out_busy;
    logic signed [POS_W-1:0]   r_out_pos, n_out_pos;
    logic                      r_out_rej, n_out_rej;

    // ------------------------------------------------------------------
    // Control decode
    // ------------------------------------------------------------------
    t_opcode                   w_op;
    logic                      w_in_acc;
    logic                      w_rate_ok;
    logic                      w_rel_ok;
    logic                      w_abs_ok;
    logic                      w_abs_move;
    logic                      w_start_div;
    logic                      w_div_step;
    logic                      w_load;
    logic                      w_abs_up;

    // Divider step
    logic [RATE_W:0]           w_trial;
    logic                      w_ge;
    logic [RATE_W:0]           w_diff;

    // Period from quotient
    logic [DIV_W-1:0]          w_quo_m1;
    logic [PERIOD_W-1:0]       w_period_new;

    assign w_op      = t_opcode'(i_opcode);
    assign w_in_acc  = i_in_valid & o_in_ready;
    assign w_rate_ok = (i_pulse_rate_hz >= RATE_W'(RATE_MIN_HZ))
                     && (i_pulse_rate_hz <= RATE_W'(RATE_MAX_HZ));
    assign w_rel_ok  = (i_move_amount > 0) && w_rate_ok;
    assign w_abs_ok  = !r_moving && w_rate_ok;
    assign w_abs_move = w_abs_ok && (i_move_amount != r_position);
    assign w_abs_up  = i_move_amount > r_position;
    assign w_start_div = ((w_op == OP_REL) && w_rel_ok)
                       || ((w_op == OP_ABS) && w_abs_move);

    // Restoring division: bring down one dividend bit, subtract if it fits
    assign w_trial = {r_rem, TICK_VEC[r_bit]};
    assign w_ge    = w_trial >= {1'b0, r_divisor};
    assign w_diff  = w_trial - {1'b0, r_divisor};

    // Period = quotient - 1, saturated to the period width
    assign w_quo_m1 = r_quo - {{(DIV_W-1){1'b0}}, 1'b1};
    always_comb begin
        if (w_quo_m1 > DIV_W'({PERIOD_W{1'b1}})) begin
            w_period_new = {PERIOD_W{1'b1}};
        end else begin
            w_period_new = w_quo_m1[PERIOD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_start_div) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        w_div_step = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // take a request when the result slot frees up this cycle
                o_in_ready = !r_out_valid || i_out_ready;
            end
            ST_DIV: begin
                w_div_step = 1'b1;
            end
            ST_LOAD: begin
                w_load = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_position  = r_position;
        n_target    = r_target;
        n_pulses    = r_pulses;
        n_dir       = r_dir;
        n_moving    = r_moving;
        n_period    = r_period;
        n_phase     = r_phase;
        n_mv_target = r_mv_target;
        n_mv_count  = r_mv_count;
        n_mv_dir    = r_mv_dir;
        n_divisor   = r_divisor;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_out_level = r_out_level;
        n_out_dir   = r_out_dir;
        n_out_busy  = r_out_busy;
        n_out_pos   = r_out_pos;
        n_out_rej   = r_out_rej;

        // drop the result once taken
        n_out_valid = r_out_valid && !i_out_ready;

        if (w_in_acc) begin
            if (w_start_div) begin
                // latch the move and arm the divider
                if (w_op == OP_REL) begin
                    n_mv_dir    = i_move_direction;
                    n_mv_count  = i_move_amount;
                    n_mv_target = i_move_direction ? (r_position + i_move_amount)
                                                   : (r_position - i_move_amount);
                end else begin
                    n_mv_dir    = w_abs_up;
                    n_mv_count  = w_abs_up ? (i_move_amount - r_position)
                                           : (r_position - i_move_amount);
                    n_mv_target = i_move_amount;
                end
                n_divisor = i_pulse_rate_hz;
                n_rem     = '0;
                n_quo     = '0;
                n_bit     = BIT_W'(DIV_W - 1);
            end else begin
                n_out_rej = 1'b0;
                unique case (w_op)
                    OP_TICK: begin
                        n_out_level = step_level(r_moving, r_phase, r_period, r_pol);
                        if (r_moving) begin
                            if (r_phase >= r_period) begin
                                // pulse done: advance position, count it off
                                n_phase    = '0;
                                n_position = r_dir ? (r_position + 1) : (r_position - 1);
                                n_pulses   = r_pulses - 1;
                                if (r_pulses == 1) begin
                                    n_moving = 1'b0;
                                end
                            end else begin
                                n_phase = r_phase + 1'b1;
                            end
                        end
                    end
                    OP_REL: begin
                        n_out_rej = 1'b1;
                    end
                    OP_ABS: begin
                        if (w_abs_ok) begin
                            // already on target: store it, no motion
                            n_target = i_move_amount;
                        end else begin
                            n_out_rej = 1'b1;
                        end
                    end
                    OP_NOP: begin
                        n_out_rej = 1'b0;
                    end
                    default: begin
                        n_out_rej = 1'b0;
                    end
                endcase
                if (w_op != OP_TICK) begin
                    n_out_level = step_level(n_moving, n_phase, n_period, r_pol);
                end
                n_out_valid = 1'b1;
                n_out_dir   = n_dir;
                n_out_busy  = n_moving;
                n_out_pos   = n_position;
            end
        end

        if (w_div_step) begin
            n_rem = w_ge ? w_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], w_ge};
            n_bit = r_bit - 1'b1;
        end

        if (w_load) begin
            // start the new move from a fresh pulse
            n_dir       = r_mv_dir;
            n_target    = r_mv_target;
            n_period    = w_period_new;
            n_phase     = '0;
            n_pulses    = r_mv_count;
            n_moving    = 1'b1;
            n_out_valid = 1'b1;
            n_out_level = step_level(1'b1, '0, w_period_new, r_pol);
            n_out_dir   = r_mv_dir;
            n_out_busy  = 1'b1;
            n_out_pos   = r_position;
            n_out_rej   = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pol       <= 1'b0;
            r_position  <= '0;
            r_target    <= '0;
            r_pulses    <= '0;
            r_dir       <= 1'b0;
            r_moving    <= 1'b0;
            r_period    <= PERIOD_RST;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_pol <= i_cfg_data;
            end
            r_position  <= n_position;
            r_target    <= n_target;
            r_pulses    <= n_pulses;
            r_dir       <= n_dir;
            r_moving    <= n_moving;
            r_period    <= n_period;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_mv_target <= n_mv_target;
        r_mv_count  <= n_mv_count;
        r_mv_dir    <= n_mv_dir;
        r_divisor   <= n_divisor;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_bit       <= n_bit;
        r_out_level <= n_out_level;
        r_out_dir   <= n_out_dir;
        r_out_busy  <= n_out_busy;
        r_out_pos   <= n_out_pos;
        r_out_rej   <= n_out_rej;
    end

    assign o_out_valid        = r_out_valid;
    assign o_step_level       = r_out_level;
    assign o_direction_out    = r_out_dir;
    assign o_busy_res         = r_out_busy;
    assign o_position         = r_out_pos;
    assign o_command_rejected = r_out_rej;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the result slot stays empty while the divider runs
    `SMPG_ASSERT(a_div_out_empty, i_clk, i_rst_n, (r_state == ST_DIV) |-> !r_out_valid)
    // the load cycle only follows the last divider step
    `SMPG_ASSERT(a_load_after_div, i_clk, i_rst_n, (r_state == ST_LOAD) |-> ($past(r_state) == ST_DIV))
    // a running move always has pulses left
    `SMPG_ASSERT(a_moving_pulses, i_clk, i_rst_n, r_moving |-> (r_pulses != '0))
    // the phase never runs past the period
    `SMPG_ASSERT(a_phase_bound, i_clk, i_rst_n, r_moving |-> (r_phase <= r_period))

endmodule

`default_nettype wire

### sim/stepper_move_checker.sv
// ----------------------------------------------------------------------------
// stepper_move_checker
// Watches the request and result channels of the step pulse generator, keeps
// its own copy of the motion state, predicts each result and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stepper_move_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic signed [smpg_pkg::POS_W-1:0] i_move_amount,
    input  logic [smpg_pkg::RATE_W-1:0]       i_pulse_rate_hz,
    input  logic                              i_move_direction,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic                              i_step_level,
    input  logic                              i_direction_out,
    input  logic                              i_busy_res,
    input  logic signed [smpg_pkg::POS_W-1:0] i_position,
    input  logic                              i_command_rejected,
    output int                                o_pending,
    output int                                o_errors
);
    import smpg_pkg::*;

    typedef struct packed {
        logic             step_level;
        logic             direction;
        logic             busy;
        logic [POS_W-1:0] position;
        logic             rejected;
    } t_motor_status;

    t_motor_status expected_status_q[$];

    logic [POS_W-1:0]    position_cnt;
    logic [POS_W-1:0]    pulses_left;
    logic                dir_cw;
    logic                moving;
    logic                polarity;
    logic [PERIOD_W-1:0] period_ticks;
    logic [PERIOD_W-1:0] phase_ticks;

    // Active level for the first half of a pulse (rounded down), idle after.
    function automatic logic step_out();
        logic [PERIOD_W:0] half_period;
        half_period = ({1'b0, period_ticks} + 1'b1) >> 1;
        if (moving && ({1'b0, phase_ticks} < half_period)) begin
            return ~polarity;
        end
        return polarity;
    endfunction

    function automatic logic rate_in_window(logic [RATE_W-1:0] rate);
        return (rate >= RATE_MIN_HZ) && (rate <= RATE_MAX_HZ);
    endfunction

    function automatic void begin_motion(logic [RATE_W-1:0] rate, logic [POS_W-1:0] count);
        int unsigned ticks_per_pulse;
        ticks_per_pulse = TICK_RATE_HZ / rate - 1;
        if (ticks_per_pulse > 32'hFFFF) begin
            ticks_per_pulse = 32'hFFFF;
        end
        period_ticks = PERIOD_W'(ticks_per_pulse);
        phase_ticks  = '0;
        pulses_left  = count;
        moving       = 1'b1;
    endfunction

    function automatic t_motor_status apply_request(t_opcode op, logic [POS_W-1:0] amount,
                                                    logic [RATE_W-1:0] rate, logic dir_in);
        t_motor_status st;
        logic          lvl;
        logic          rej;
        logic          up;
        rej = 1'b0;
        lvl = step_out();
        case (op)
            OP_TICK: begin
                // level is the one seen during the tick, so take it first
                if (moving) begin
                    if (phase_ticks >= period_ticks) begin
                        phase_ticks  = '0;
                        position_cnt = dir_cw ? position_cnt + 1 : position_cnt - 1;
                        pulses_left  = pulses_left - 1;
                        if (pulses_left == '0) begin
                            moving = 1'b0;
                        end
                    end else begin
                        phase_ticks = phase_ticks + 1'b1;
                    end
                end
            end
            OP_REL: begin
                if (amount == '0 || amount[POS_W-1] || !rate_in_window(rate)) begin
                    rej = 1'b1;
                end else begin
                    dir_cw = dir_in;
                    begin_motion(rate, amount);
                end
                lvl = step_out();
            end
            OP_ABS: begin
                if (moving || !rate_in_window(rate)) begin
                    rej = 1'b1;
                end else if (amount != position_cnt) begin
                    up     = $signed(amount) > $signed(position_cnt);
                    dir_cw = up;
                    begin_motion(rate, up ? amount - position_cnt : position_cnt - amount);
                end
                lvl = step_out();
            end
            default: begin
                lvl = step_out();
            end
        endcase
        st.step_level = lvl;
        st.direction  = dir_cw;
        st.busy       = moving;
        st.position   = position_cnt;
        st.rejected   = rej;
        return st;
    endfunction

    task automatic note_error(string what);
        o_errors++;
        if (o_errors <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_motor_status seen;
        t_motor_status want;
        if (!i_rst_n) begin
            position_cnt = '0;
            pulses_left  = '0;
            dir_cw       = 1'b0;
            moving       = 1'b0;
            polarity     = 1'b0;
            period_ticks = PERIOD_RST;
            phase_ticks  = '0;
            expected_status_q.delete();
            o_pending = 0;
        end else begin
            // compare before predicting: a result never belongs to a request
            // taken at the same edge
            if (i_out_valid && i_out_ready) begin
                seen.step_level = i_step_level;
                seen.direction  = i_direction_out;
                seen.busy       = i_busy_res;
                seen.position   = i_position;
                seen.rejected   = i_command_rejected;
                if (expected_status_q.size() == 0) begin
                    note_error($sformatf("result with nothing pending: %p", seen));
                end else begin
                    want = expected_status_q.pop_front();
                    if (seen.step_level !== want.step_level)
                        note_error($sformatf("step level: expected %0b, got %0b",
                                             want.step_level, seen.step_level));
                    if (seen.direction !== want.direction)
                        note_error($sformatf("direction: expected %0b, got %0b",
                                             want.direction, seen.direction));
                    if (seen.busy !== want.busy)
                        note_error($sformatf("busy: expected %0b, got %0b",
                                             want.busy, seen.busy));
                    if (seen.position !== want.position)
                        note_error($sformatf("position: expected %0d, got %0d",
                                             $signed(want.position), $signed(seen.position)));
                    if (seen.rejected !== want.rejected)
                        note_error($sformatf("reject flag: expected %0b, got %0b",
                                             want.rejected, seen.rejected));
                end
            end
            if (i_cfg_we) begin
                polarity = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                expected_status_q.push_back(apply_request(t_opcode'(i_opcode), i_move_amount,
                                                          i_pulse_rate_hz, i_move_direction));
            end
            o_pending = expected_status_q.size();
        end
    end

endmodule

### sim/stepper_move_pulse_generator_test.sv
// ----------------------------------------------------------------------------
// stepper_move_pulse_generator_test
// Drives ticks, relative and absolute moves into the step pulse generator
// with bursty requests and a stalling receiver; a checker beside the block
// predicts every result and the top reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stepper_move_pulse_generator_test;
    import smpg_pkg::*;

    localparam int          CLK_PERIOD_NS    = 10;
    localparam int unsigned RUN_LIMIT_NS     = 5_000_000;
    localparam int          SETTLE_CYCLES    = 30;
    localparam int          LONG_HOLD_CYCLES = 80;
    localparam int          PHASE_ITEMS      = 125;

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_we         = 1'b0;
    logic                      i_cfg_data       = 1'b0;
    logic                      i_in_valid       = 1'b0;
    t_opcode                   req_op           = OP_TICK;
    logic signed [POS_W-1:0]   req_amount       = '0;
    logic [RATE_W-1:0]         req_rate         = '0;
    logic                      req_dir          = 1'b0;
    logic                      i_out_ready      = 1'b0;

    logic                      o_in_ready;
    logic                      o_out_valid;
    logic                      o_step_level;
    logic                      o_direction_out;
    logic                      o_busy_res;
    logic signed [POS_W-1:0]   o_position;
    logic                      o_command_rejected;

    int checker_pending;
    int checker_errors;
    int items_sent    = 0;
    int burst_left    = 0;
    bit long_hold_req = 1'b0;

    always #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;

    stepper_move_pulse_generator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (req_op),
        .i_move_amount      (req_amount),
        .i_pulse_rate_hz    (req_rate),
        .i_move_direction   (req_dir),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_step_level       (o_step_level),
        .o_direction_out    (o_direction_out),
        .o_busy_res         (o_busy_res),
        .o_position         (o_position),
        .o_command_rejected (o_command_rejected)
    );

    stepper_move_checker motion_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_opcode           (req_op),
        .i_move_amount      (req_amount),
        .i_pulse_rate_hz    (req_rate),
        .i_move_direction   (req_dir),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_step_level       (o_step_level),
        .i_direction_out    (o_direction_out),
        .i_busy_res         (o_busy_res),
        .i_position         (o_position),
        .i_command_rejected (o_command_rejected),
        .o_pending          (checker_pending),
        .o_errors           (checker_errors)
    );

    // Offer one request and hold it until it is taken. Requests go out in
    // bursts of random length; between bursts drop valid for a random gap,
    // and skip the gap now and then so back-to-back streams happen too.
    task automatic offer(t_opcode op, logic [POS_W-1:0] amount,
                         logic [RATE_W-1:0] rate, logic dir);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
        burst_left--;
        req_op     <= op;
        req_amount <= amount;
        req_rate   <= rate;
        req_dir    <= dir;
        i_in_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Ticks carry random payload: the block must ignore it, and it toggles
    // every bit of every field.
    task automatic tick_run(int count);
        repeat (count) begin
            offer(OP_TICK, $urandom, RATE_W'($urandom), 1'($urandom));
        end
    endtask

    // Stop offering and hold until every pending result is back, then let
    // the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (checker_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_polarity(logic value);
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly fast rates so pulses finish within a short tick run; some slow
    // ones inside the window and a few outside it.
    function automatic logic [RATE_W-1:0] pick_rate();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                return RATE_W'($urandom_range(0, RATE_MIN_HZ - 1));
            end
            return RATE_W'($urandom_range(RATE_MAX_HZ + 1, 20'hFFFFF));
        end
        if (roll < 3) begin
            return RATE_W'($urandom_range(RATE_MIN_HZ, RATE_MAX_HZ));
        end
        return RATE_W'($urandom_range(50000, RATE_MAX_HZ));
    endfunction

    // A well-formed move: a command followed by a run of ticks, with the
    // occasional interruption (replacing move, absolute move while busy,
    // malformed relative move, unused code).
    task automatic move_sequence();
        int run_len;
        if ($urandom_range(0, 3) == 0) begin
            offer(OP_ABS, POS_W'(int'($urandom_range(0, 16)) - 8), pick_rate(),
                  1'($urandom_range(0, 1)));
        end else begin
            offer(OP_REL, POS_W'($urandom_range(1, 4)), pick_rate(), 1'($urandom_range(0, 1)));
        end
        run_len = $urandom_range(5, 70);
        repeat (run_len) begin
            if ($urandom_range(0, 24) == 0) begin
                case ($urandom_range(0, 3))
                    0: offer(OP_REL, POS_W'($urandom_range(1, 3)), pick_rate(),
                             1'($urandom_range(0, 1)));
                    1: offer(OP_ABS, POS_W'(int'($urandom_range(0, 16)) - 8), pick_rate(),
                             1'($urandom_range(0, 1)));
                    2: offer(OP_REL, POS_W'(-int'($urandom_range(0, 3))), pick_rate(),
                             1'($urandom_range(0, 1)));
                    default: offer(OP_NOP, $urandom, RATE_W'($urandom), 1'($urandom));
                endcase
            end
            tick_run(1);
        end
    endtask

    // Fully random request: any code, any amount, any rate.
    task automatic noise_item();
        offer(t_opcode'($urandom_range(0, 3)), $urandom, RATE_W'($urandom), 1'($urandom));
    endtask

    // Receiver: switch between stall patterns over random spans. A long
    // hold-off, when asked for, is counted here so the block fills up and
    // drops its input ready while the sender keeps offering.
    initial begin : result_drain
        int mode;
        int span_left;
        int hold_left;
        bit hold_taken;
        mode       = 0;
        span_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req && !hold_taken) begin
                hold_taken  = 1'b1;
                i_out_ready <= 1'b0;
                hold_left   = LONG_HOLD_CYCLES - 1;
            end else begin
                if (span_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    span_left = $urandom_range(8, 60);
                end
                span_left--;
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 1) == 1);
                    2:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int phase_end;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_polarity(1'b0);

        // Directed: rate window edges, refusals, replacement, one full pulse,
        // target on the current position, long absolute distances.
        tick_run(1);                                            // idle tick
        offer(OP_REL, 32'd5, RATE_W'(RATE_MIN_HZ - 1), 1'b1);   // rate just below
        offer(OP_REL, 32'd5, RATE_W'(RATE_MAX_HZ + 1), 1'b1);   // rate just above
        offer(OP_REL, 32'd1, RATE_W'(RATE_MIN_HZ), 1'b0);       // slowest period
        tick_run(2);
        offer(OP_ABS, 32'd7, 20'd1000, 1'b0);                   // absolute while busy
        offer(OP_REL, 32'd1, RATE_W'(RATE_MAX_HZ), 1'b1);       // replace, fastest
        tick_run(10);                                           // one whole pulse
        offer(OP_REL, 32'd0, 20'd1000, 1'b1);                   // zero amount
        offer(OP_REL, 32'h8000_0000, 20'd1000, 1'b1);           // most negative amount
        offer(OP_REL, 32'h7FFF_FFFF, 20'hFFFFF, 1'b0);          // rate field all ones
        offer(OP_ABS, 32'd1, 20'd1000, 1'b0);                   // target already reached
        offer(OP_ABS, 32'd5, 20'd0, 1'b1);                      // zero rate
        offer(OP_ABS, 32'h8000_0000, RATE_W'(RATE_MAX_HZ), 1'b0); // long way down
        tick_run(1);
        offer(OP_NOP, '1, '1, 1'b1);                            // unused code
        offer(OP_REL, 32'h7FFF_FFFF, RATE_W'(RATE_MAX_HZ), 1'b1); // largest count
        tick_run(3);
        offer(OP_REL, 32'd2, RATE_W'(RATE_MAX_HZ), 1'b0);       // back below zero
        tick_run(22);
        offer(OP_ABS, 32'h7FFF_FFFF, RATE_W'(RATE_MAX_HZ), 1'b1); // long way up
        tick_run(1);

        // Random phases; flip the polarity between them while the block is
        // idle, and ask the receiver for one long hold-off in the second.
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            set_polarity(phase % 2 == 0);
            if (phase == 1) begin
                long_hold_req <= 1'b1;
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1:    noise_item();
                    2:       tick_run($urandom_range(1, 12));
                    default: move_sequence();
                endcase
            end
        end

        drain_results();
        if (checker_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
